### hw/rtl/api_frame_rx_checker_assert.svh
// Assertion macros used by the frame tracking module of the receive checker.
`ifndef API_FRAME_RX_CHECKER_ASSERT_SVH
`define API_FRAME_RX_CHECKER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define AFRC_ASSERT_ALWAYS(lbl, clk_sig, rst_n_sig, cond) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (cond)) \
		else $error("frame receive checker: invariant violated");

// Checks that a condition holds in the cycle after a trigger.
`define AFRC_ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("frame receive checker: sequence violated");

`endif

### hw/rtl/afrc_pkg.sv
// Types and constants of the API frame receive checker.
package afrc_pkg;

	localparam int FRAME_BYTES = 10;
	localparam int POS_W       = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [POS_W-1:0] LEN_HI_POS  = POS_W'(1);
	localparam logic [POS_W-1:0] LEN_LO_POS  = POS_W'(2);
	localparam logic [POS_W-1:0] API_POS     = POS_W'(3);
	localparam logic [POS_W-1:0] PAYLOAD_POS = POS_W'(8);
	localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES - 1);
	localparam logic [7:0]       SUM_GOOD    = 8'd255;

	localparam logic [7:0]  START_DELIMITER_RST = 8'd126;
	localparam logic [15:0] EXPECTED_LENGTH_RST = 16'd6;
	localparam logic [7:0]  EXPECTED_API_ID_RST = 8'd129;

	typedef enum logic [2:0] {
		ST_DISCARD = 3'd0,
		ST_MID     = 3'd1,
		ST_OK      = 3'd2,
		ST_BAD_LEN = 3'd3,
		ST_BAD_API = 3'd4,
		ST_BAD_SUM = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_DELIMITER = 2'd0,
		CFG_EXPECTED_LENGTH = 2'd1,
		CFG_EXPECTED_API_ID = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [7:0]  start_delimiter;
		logic [15:0] expected_length;
		logic [7:0]  expected_api_id;
	} cfg_t;

endpackage

### hw/rtl/afrc_if.sv
// Valid/ready channel interfaces for received bytes and check results.
interface afrc_byte_if import afrc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface afrc_result_if import afrc_pkg::*; ();
	logic       valid;
	logic       ready;
	status_t    status;
	logic [7:0] charge_byte;

	modport source (output valid, output status, output charge_byte, input ready);
	modport sink (input valid, input status, input charge_byte, output ready);
endinterface

### hw/rtl/afrc_cfg_regs.sv
// Configuration register file of the frame receive checker.
module afrc_cfg_regs import afrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delimiter <= START_DELIMITER_RST;
			cfg_q.expected_length <= EXPECTED_LENGTH_RST;
			cfg_q.expected_api_id <= EXPECTED_API_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_DELIMITER: cfg_q.start_delimiter <= cfg_wdata[7:0];
				CFG_EXPECTED_LENGTH: cfg_q.expected_length <= cfg_wdata[15:0];
				CFG_EXPECTED_API_ID: cfg_q.expected_api_id <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/afrc_frame.sv
// Frame tracking state and per-byte check logic of the frame receive checker.
`include "api_frame_rx_checker_assert.svh"

module afrc_frame import afrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	input  cfg_t       cfg,
	output status_t    status_d,
	output logic [7:0] charge_d
);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [7:0]       sum_q, sum_n;
	logic             len_mis_q, len_mis_n;
	logic             api_mis_q, api_mis_n;
	logic [7:0]       pend_q, pend_n;
	logic [7:0]       charge_q;

	always_comb begin
		pos_n     = pos_q;
		sum_n     = sum_q;
		len_mis_n = len_mis_q;
		api_mis_n = api_mis_q;
		pend_n    = pend_q;
		charge_d  = charge_q;
		status_d  = ST_MID;

		if (pos_q == '0) begin
			if (byte_in != cfg.start_delimiter) begin
				status_d = ST_DISCARD;
			end else begin
				// Opening byte starts a fresh frame.
				sum_n     = '0;
				len_mis_n = 1'b0;
				api_mis_n = 1'b0;
				pend_n    = '0;
				pos_n     = POS_W'(1);
			end
		end else begin
			if (pos_q == LEN_HI_POS && byte_in != cfg.expected_length[15:8]) begin
				len_mis_n = 1'b1;
			end
			if (pos_q == LEN_LO_POS && byte_in != cfg.expected_length[7:0]) begin
				len_mis_n = 1'b1;
			end
			if (pos_q == API_POS && byte_in != cfg.expected_api_id) begin
				api_mis_n = 1'b1;
			end
			if (pos_q >= API_POS) begin
				sum_n = sum_q + byte_in;
			end
			if (pos_q == PAYLOAD_POS) begin
				pend_n = byte_in;
			end

			if (pos_q == LAST_POS) begin
				pos_n = '0;
				if (len_mis_n) begin
					status_d = ST_BAD_LEN;
				end else if (api_mis_n) begin
					status_d = ST_BAD_API;
				end else if (sum_n != SUM_GOOD) begin
					status_d = ST_BAD_SUM;
				end else begin
					status_d = ST_OK;
					charge_d = pend_n;
				end
			end else begin
				pos_n = pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			len_mis_q <= 1'b0;
			api_mis_q <= 1'b0;
			pend_q    <= '0;
			charge_q  <= '0;
		end else if (step) begin
			pos_q     <= pos_n;
			sum_q     <= sum_n;
			len_mis_q <= len_mis_n;
			api_mis_q <= api_mis_n;
			pend_q    <= pend_n;
			charge_q  <= charge_d;
		end
	end

	`AFRC_ASSERT_ALWAYS(a_pos_in_frame, clk, arst_n, pos_q <= LAST_POS)
	`AFRC_ASSERT_NEXT(a_discard_stays_closed, clk, arst_n, step && status_d == ST_DISCARD, pos_q == '0)
	`AFRC_ASSERT_NEXT(a_ok_loads_charge, clk, arst_n, step && status_d == ST_OK, pos_q == '0 && charge_q == $past(pend_n))

endmodule

### hw/rtl/api_frame_rx_checker.sv
// Top level of the API frame receive checker.

// The checker takes one received serial byte per transfer on rx and returns
// exactly one result transfer on result for every byte: a status code
// (discarded, accepted mid-frame, frame ok, bad length, bad API identifier,
// bad checksum) and the charge byte of the last good frame. It sustains one
// byte per clock cycle unless the result side stalls. Each byte passes the
// input register, then the result register, and needs only one pass through
// the check logic, since the checksum is kept as a running sum. A start
// delimiter opens a frame of FRAME_BYTES bytes; the length, API identifier
// and checksum verdict appear with the last byte. Configuration registers
// (start delimiter, expected length, expected API identifier) are written
// through cfg_we, cfg_index and cfg_wdata; the user must do so only while
// the block is idle, which it does not enforce; unused indices are ignored.
module api_frame_rx_checker import afrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	afrc_byte_if.sink             rx,
	afrc_result_if.source         result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t       cfg;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic       out_valid_q;
	status_t    status_q;
	logic [7:0] charge_q;

	status_t    status_d;
	logic [7:0] charge_d;
	logic       advance;
	logic       step;

	afrc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The result register can take a new value when it is empty or its
	// current result is being transferred out in this cycle.
	assign advance  = !out_valid_q || result.ready;
	assign step     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	// The frame state only moves when the held byte is committed to the
	// result register, so a stall on the result side never loses a byte.
	afrc_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_in  (byte_s1),
		.cfg      (cfg),
		.status_d (status_d),
		.charge_d (charge_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers need no reset; they are qualified by the valid flags.
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (step) begin
			status_q <= status_d;
			charge_q <= charge_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.status      = status_q;
	assign result.charge_byte = charge_q;

endmodule

### verif/tb_api_frame_rx_checker.sv
// Self-checking testbench for the API frame receive checker.
`timescale 1ns / 1ps

module tb_api_frame_rx_checker;
	import afrc_pkg::*;

	// Frame layout, as the block sees it. The testbench keeps its own copy
	// so that it does not lean on the block's own constants.
	localparam int        FRAME_LEN   = 10;
	localparam int        LEN_HI_IDX  = 1;
	localparam int        LEN_LO_IDX  = 2;
	localparam int        API_IDX     = 3;
	localparam int        PAYLOAD_IDX = 8;
	localparam logic [7:0] SUM_TARGET = 8'hFF;

	// Index 3 is decoded by nothing in the block, so a write there must be lost.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	localparam int NUM_PHASES       = 12;
	localparam int FRAMES_PER_PHASE = 13;
	localparam int LONG_HOLD        = 300;
	localparam int STALL_LIMIT      = 2000;
	localparam int MAX_REPORTS      = 10;

	typedef logic [7:0] frame_t [FRAME_LEN];

	typedef struct {
		status_t    status;
		logic [7:0] charge_byte;
	} frame_result_t;

	typedef enum {
		FLAW_NONE,
		FLAW_LEN_HI,
		FLAW_LEN_LO,
		FLAW_API,
		FLAW_SUM,
		FLAW_MULTI
	} frame_flaw_t;

	// Mirrors the frame tracking of the block and holds the results that
	// the accepted bytes are still owed.
	class frame_scoreboard;
		logic [7:0]      delimiter;
		logic [15:0]     length_req;
		logic [7:0]      api_req;
		int              position;
		logic [7:0]      sum;
		bit              len_bad;
		bit              api_bad;
		logic [7:0]      payload;
		logic [7:0]      charge;
		frame_result_t   expected_q[$];
		int              mismatches;

		function new();
			delimiter  = 8'd126;
			length_req = 16'd6;
			api_req    = 8'd129;
			position   = 0;
			sum        = 8'd0;
			len_bad    = 1'b0;
			api_bad    = 1'b0;
			payload    = 8'd0;
			charge     = 8'd0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_START_DELIMITER: delimiter  = data[7:0];
				CFG_EXPECTED_LENGTH: length_req = data[15:0];
				CFG_EXPECTED_API_ID: api_req    = data[7:0];
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b);
			frame_result_t r;
			r.status = ST_MID;
			if (position == 0 && b != delimiter) begin
				r.status = ST_DISCARD;
			end else begin
				if (position == 0) begin
					sum     = 8'd0;
					len_bad = 1'b0;
					api_bad = 1'b0;
					payload = 8'd0;
				end else begin
					if (position == LEN_HI_IDX && b != length_req[15:8])
						len_bad = 1'b1;
					if (position == LEN_LO_IDX && b != length_req[7:0])
						len_bad = 1'b1;
					if (position == API_IDX && b != api_req)
						api_bad = 1'b1;
					if (position >= API_IDX)
						sum = sum + b;
					if (position == PAYLOAD_IDX)
						payload = b;
				end
				position++;
				if (position >= FRAME_LEN) begin
					if (len_bad) begin
						r.status = ST_BAD_LEN;
					end else if (api_bad) begin
						r.status = ST_BAD_API;
					end else if (sum != SUM_TARGET) begin
						r.status = ST_BAD_SUM;
					end else begin
						r.status = ST_OK;
						charge   = payload;
					end
					position = 0;
				end
			end
			r.charge_byte = charge;
			expected_q.push_back(r);
		endfunction

		function void check_result(status_t status, logic [7:0] charge_byte);
			frame_result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: status %0d charge %02h", status, charge_byte);
				return;
			end
			e = expected_q.pop_front();
			if (status !== e.status || charge_byte !== e.charge_byte) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result mismatch: status exp %0d got %0d, charge exp %02h got %02h",
						e.status, status, e.charge_byte, charge_byte);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	afrc_byte_if   rx_ch();
	afrc_result_if res_ch();

	frame_scoreboard sb = new();

	// Random idling on both channels is switched per phase; the long hold-off
	// of the result side is requested by the stimulus and timed by the receiver.
	bit idling_on    = 1'b0;
	bit hold_request = 1'b0;
	int quiet_cycles;

	api_frame_rx_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Both channels are sampled in the active region of the rising edge, so
	// the values seen are the ones the block itself sampled at that edge.
	// A byte transfer is booked before a result transfer of the same edge;
	// across the input and result registers they never belong to each other.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready)
				sb.note_byte(rx_ch.rx_byte);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.status, res_ch.charge_byte);
		end
	end

	// Watchdog: a run that goes this long without any transfer on either
	// channel is hung. The limit covers the long hold-off several times over.
	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side. It either takes the long hold-off that was asked for,
	// or stalls for a random burst while idling is on, or stays ready.
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Offers one byte and returns at the edge where it is transferred. The
	// valid line is left high so that back-to-back bytes follow without a gap.
	task automatic send_byte(input logic [7:0] b);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_bytes(input frame_t fr, input int from, input int upto);
		for (int i = from; i < upto; i++)
			send_byte(fr[i]);
	endtask

	// Drops valid and waits until every byte sent so far has its result.
	// The first edge lets the last byte transfer be booked before the
	// queue is looked at.
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// One register write, only ever issued while the block is drained.
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Builds a frame that matches the current settings, then spoils the
	// fields that the flaw names. The last byte is chosen so that bytes
	// three to nine add up to 255 unless the checksum itself is spoiled.
	task automatic build_frame(input frame_flaw_t flaw, input bit delim_inside, output frame_t fr);
		logic [7:0] acc;
		fr[0]          = sb.delimiter;
		fr[LEN_HI_IDX] = sb.length_req[15:8];
		fr[LEN_LO_IDX] = sb.length_req[7:0];
		fr[API_IDX]    = sb.api_req;
		for (int i = API_IDX + 1; i < FRAME_LEN - 1; i++)
			fr[i] = ($urandom_range(0, 3) == 0) ? sb.delimiter : 8'($urandom_range(0, 255));
		// A delimiter inside an open frame is plain data and must not restart it.
		if (delim_inside)
			fr[API_IDX + 1] = sb.delimiter;
		if (flaw == FLAW_LEN_HI)
			fr[LEN_HI_IDX] ^= 8'($urandom_range(1, 255));
		if (flaw == FLAW_LEN_LO || flaw == FLAW_MULTI)
			fr[LEN_LO_IDX] ^= 8'($urandom_range(1, 255));
		if (flaw == FLAW_API || flaw == FLAW_MULTI)
			fr[API_IDX] ^= 8'($urandom_range(1, 255));
		acc = 8'd0;
		for (int i = API_IDX; i < FRAME_LEN - 1; i++)
			acc = acc + fr[i];
		fr[FRAME_LEN-1] = SUM_TARGET - acc;
		if (flaw == FLAW_SUM || flaw == FLAW_MULTI)
			fr[FRAME_LEN-1] = fr[FRAME_LEN-1] + 8'($urandom_range(1, 255));
	endtask

	// Half the frames are good; the rest carry one flaw each, or several at once
	// to check that the verdict follows the length, API, checksum order.
	function automatic frame_flaw_t pick_flaw();
		case ($urandom_range(0, 9))
			5: return FLAW_LEN_HI;
			6: return FLAW_LEN_LO;
			7: return FLAW_API;
			8: return FLAW_SUM;
			9: return FLAW_MULTI;
			default: return FLAW_NONE;
		endcase
	endfunction

	// Line noise between frames. Now and then it happens to hit the
	// delimiter, which opens a frame early and misaligns what follows.
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 15) != 0)
			while (b == sb.delimiter)
				b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	// Register values lean on the ends of their range.
	function automatic logic [15:0] pick_setting(input logic [15:0] max_val);
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return max_val;
			default: return 16'($urandom_range(0, max_val));
		endcase
	endfunction

	initial begin
		frame_t fr;
		int     cut;
		bit     partial;

		arst_n        = 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= 8'd0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: both byte extremes are
		// discarded while no frame is open, then a good frame that carries
		// the delimiter as data.
		send_byte(8'h00);
		send_byte(8'hFF);
		build_frame(FLAW_NONE, 1'b1, fr);
		send_bytes(fr, 0, FRAME_LEN);
		drain();

		// Extreme settings, plus a write to the unused index that must not
		// disturb any of them. A frame with a wrong API byte follows.
		write_cfg(CFG_START_DELIMITER, 16'h0000);
		write_cfg(CFG_EXPECTED_LENGTH, 16'hFFFF);
		write_cfg(CFG_EXPECTED_API_ID, 16'h00FF);
		write_cfg(CFG_UNUSED_IDX, 16'hFFFF);
		build_frame(FLAW_API, 1'b0, fr);
		send_bytes(fr, 0, FRAME_LEN);
		drain();

		// Random phases. Each one runs under its own settings; some run with
		// idling on both sides and some without, and the last ones never idle.
		// A phase may end in the middle of a frame, so the next settings take
		// effect on the bytes of a frame that is already open.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			idling_on = (ph < NUM_PHASES - 2) && (ph % 3 != 1);
			// The result side holds off for a long stretch while bytes keep
			// coming, so the block fills up and must stall its byte input.
			if (ph == 2)
				hold_request = 1'b1;
			for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) send_byte(noise_byte());
				build_frame(pick_flaw(), $urandom_range(0, 3) == 0, fr);
				send_bytes(fr, 0, FRAME_LEN);
			end
			partial = (ph < NUM_PHASES - 1) && ($urandom_range(0, 1) == 1);
			cut     = $urandom_range(1, FRAME_LEN - 1);
			if (partial) begin
				build_frame(pick_flaw(), 1'b0, fr);
				send_bytes(fr, 0, cut);
			end
			drain();
			if (ph < NUM_PHASES - 1) begin
				if ($urandom_range(0, 2) != 0)
					write_cfg(CFG_START_DELIMITER, pick_setting(16'h00FF));
				if ($urandom_range(0, 2) != 0)
					write_cfg(CFG_EXPECTED_LENGTH, pick_setting(16'hFFFF));
				if ($urandom_range(0, 2) != 0)
					write_cfg(CFG_EXPECTED_API_ID, pick_setting(16'h00FF));
				if ($urandom_range(0, 5) == 0)
					write_cfg(CFG_UNUSED_IDX, 16'($urandom_range(0, 16'hFFFF)));
			end
			if (partial) begin
				build_frame(pick_flaw(), 1'b0, fr);
				send_bytes(fr, cut, FRAME_LEN);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### api_frame_rx_checker.f
+incdir+hw/rtl
hw/rtl/afrc_pkg.sv
hw/rtl/afrc_if.sv
hw/rtl/afrc_cfg_regs.sv
hw/rtl/afrc_frame.sv
hw/rtl/api_frame_rx_checker.sv
verif/tb_api_frame_rx_checker.sv
